// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VRR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vrr assertion failed");

// next-cycle implication
`define VRR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vrr assertion failed");

`endif

// File: sv/vrr_pkg.sv
// ----------------------------------------------------------------------------
// vrr_pkg
// Shared widths, request and register codes and saturation for the rope core.
// ----------------------------------------------------------------------------
package vrr_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int RELAX_PASSES   = 12;

  localparam int REQ_W = 3;
  localparam int IDX_W = 6;
  localparam int CRD_W = 32;
  localparam int DT_W  = 16;
  localparam int CFG_W = 2;

  localparam logic signed [16:0] DAMP_Q16 = 17'sd62259;

  localparam logic [REQ_W-1:0] REQ_LOAD   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PREV   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ANCHOR = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FORCE  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_STEP   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd6;

  localparam logic [CFG_W-1:0] CFG_GRAVITY = 2'd0;
  localparam logic [CFG_W-1:0] CFG_REST    = 2'd1;
  localparam logic [CFG_W-1:0] CFG_COUNT   = 2'd2;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7fffffff;
    if (v < -40'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// File: sv/verlet_rope_relaxation_core.sv
// ----------------------------------------------------------------------------
// verlet_rope_relaxation_core
// Load, previous, anchor, clear and force words are handled in idle; read
// emits n points. Step (n points) integrates each point, then for n >= 2
// runs 12 relaxation passes over the segments, each segment using the
// 32-step bit-serial square root and up to two 36-step divisions, then
// emits the n points. Synchronous active-low reset returns to idle and
// clears force, anchor flags, valid bits, config (count=1); no clearing pass.
// ----------------------------------------------------------------------------
module verlet_rope_relaxation_core #(
  parameter int MAX_POINTS = vrr_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [vrr_pkg::REQ_W-1:0]         in_req_type,
  input  logic [vrr_pkg::IDX_W-1:0]         in_point_index,
  input  logic signed [vrr_pkg::CRD_W-1:0]  in_x_value,
  input  logic signed [vrr_pkg::CRD_W-1:0]  in_y_value,
  input  logic [vrr_pkg::DT_W-1:0]          in_time_step,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vrr_pkg::IDX_W-1:0]         out_index,
  output logic signed [vrr_pkg::CRD_W-1:0]  out_pos_x,
  output logic signed [vrr_pkg::CRD_W-1:0]  out_pos_y,
  output logic                              out_last_point,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vrr_pkg::CFG_W-1:0]         cfg_index,
  input  logic [31:0]                       cfg_data
);
  import vrr_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_I_RD   = 5'd1;
  localparam logic [4:0] ST_I_MUL  = 5'd2;
  localparam logic [4:0] ST_I_WR   = 5'd3;
  localparam logic [4:0] ST_R_LD   = 5'd4;
  localparam logic [4:0] ST_R_LDW  = 5'd5;
  localparam logic [4:0] ST_S_RD   = 5'd6;
  localparam logic [4:0] ST_S_GET  = 5'd7;
  localparam logic [4:0] ST_S_DIFF = 5'd8;
  localparam logic [4:0] ST_S_SQ1  = 5'd9;
  localparam logic [4:0] ST_S_SQ2  = 5'd10;
  localparam logic [4:0] ST_S_SQRT = 5'd11;
  localparam logic [4:0] ST_S_CHK  = 5'd12;
  localparam logic [4:0] ST_S_MLO  = 5'd13;
  localparam logic [4:0] ST_S_MHI  = 5'd14;
  localparam logic [4:0] ST_S_DIV  = 5'd15;
  localparam logic [4:0] ST_S_APP  = 5'd16;
  localparam logic [4:0] ST_S_WB   = 5'd17;
  localparam logic [4:0] ST_R_END  = 5'd18;
  localparam logic [4:0] ST_E_RD   = 5'd19;
  localparam logic [4:0] ST_E_OUT  = 5'd20;

  logic [4:0]             state_r;
  logic signed [31:0]     gravity_r;
  logic [30:0]            rest_r;
  logic [6:0]             count_r;
  logic signed [31:0]     force_x_r, force_y_r;
  logic [MAX_POINTS-1:0]  pos_vld_r, prev_vld_r, anchor_r;
  logic [AW-1:0]          idx_r, seg_r, seg_p1;
  logic [3:0]             pass_r;
  logic [5:0]             cnt_r;
  logic                   axis_r;
  logic                   out_valid_r;

  logic [63:0] pos_mem  [MAX_POINTS];
  logic [63:0] prev_mem [MAX_POINTS];
  logic [63:0] anc_mem  [MAX_POINTS];
  logic [63:0] pos_rd_r, prev_rd_r, anc_rd_r, pos_q, prev_q;
  logic [AW-1:0] ra, ra_r, pos_wa, prev_wa;
  logic [63:0]   pos_wd, prev_wd;
  logic          pos_we, prev_we, anc_we;

  logic          in_fire, idx_ok, out_ld, last_pt, anchored;
  logic [AW-1:0] in_idx;
  logic [NW-1:0] n_use, n_m1;

  logic [15:0]        dt_r;
  logic signed [31:0] ipx_r, ipy_r;
  logic signed [49:0] mvx_r, mvy_r, mdx_r, mdy_r;
  logic signed [49:0] mvx, mvy, mdx, mdy, rvx, rvy, rdx, rdy;
  logic signed [32:0] dpx, dpy, accx, accy;
  logic signed [16:0] dts;
  logic signed [31:0] newx, newy;

  logic signed [31:0] cx_r, cy_r, nx_r, ny_r;
  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;
  logic [31:0]        ax_r, ay_r, opa;
  logic               dxn_r, dyn_r, sh_r;
  logic [30:0]        axs_r, ays_r;
  logic [61:0]        sqx_r, sqy;
  logic [63:0]        rad_r;
  logic [33:0]        sq_rem_r;
  logic [31:0]        root_r;
  logic [35:0]        trem, trial;
  logic               sq_ge;
  logic [32:0]        dlen;
  logic               f1, f2, skip, f1_r, f2_r;
  logic signed [34:0] kval;
  logic [33:0]        kabs_r, den_r;
  logic               kneg_r;
  logic [48:0]        plo_r, phi;
  logic [66:0]        num;
  logic [33:0]        div_rem_r;
  logic [35:0]        div_q_r;
  logic [34:0]        dtr;
  logic               dge;
  logic signed [36:0] corr;
  logic               cneg;
  logic signed [31:0] p1, p2, s1, s2;
  logic [IDX_W-1:0]   out_index_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic               out_last_r;

  assign in_ready       = (state_r == ST_IDLE);
  assign in_fire        = in_valid && in_ready;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_index      = out_index_r;
  assign out_pos_x      = out_x_r;
  assign out_pos_y      = out_y_r;
  assign out_last_point = out_last_r;

  assign idx_ok   = ({1'b0, in_point_index} < 7'(MAX_POINTS));
  assign in_idx   = in_point_index[AW-1:0];
  assign n_use    = (count_r > 7'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(count_r);
  assign n_m1     = n_use - NW'(1);
  assign seg_p1   = seg_r + AW'(1);
  assign last_pt  = ((NW'(idx_r) + NW'(1)) == n_use);
  assign out_ld   = (state_r == ST_E_OUT) && (!out_valid_r || out_ready);
  assign anchored = anchor_r[idx_r];

  assign pos_q  = pos_vld_r[ra_r]  ? pos_rd_r  : '0;
  assign prev_q = prev_vld_r[ra_r] ? prev_rd_r : '0;

  // integration arithmetic
  assign dpx  = 33'($signed(pos_q[31:0]))  - 33'($signed(prev_q[31:0]));
  assign dpy  = 33'($signed(pos_q[63:32])) - 33'($signed(prev_q[63:32]));
  assign accx = 33'(force_x_r);
  assign accy = 33'(force_y_r) + 33'(gravity_r);
  assign dts  = $signed({1'b0, dt_r});
  assign mvx  = dpx * DAMP_Q16;
  assign mvy  = dpy * DAMP_Q16;
  assign mdx  = accx * dts;
  assign mdy  = accy * dts;
  assign rvx  = mvx_r + 50'sd32768;
  assign rvy  = mvy_r + 50'sd32768;
  assign rdx  = mdx_r + 50'sd32768;
  assign rdy  = mdy_r + 50'sd32768;
  assign newx = sat32(40'(ipx_r) + 40'($signed(rvx[49:16])) + 40'($signed(rdx[49:16])));
  assign newy = sat32(40'(ipy_r) + 40'($signed(rvy[49:16])) + 40'($signed(rdy[49:16])));

  // segment arithmetic
  assign dx    = 33'(nx_r) - 33'(cx_r);
  assign dy    = 33'(ny_r) - 33'(cy_r);
  assign adx   = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady   = dy[32] ? 33'(-dy) : 33'(dy);
  assign sqy   = ays_r * ays_r;
  assign trem  = {sq_rem_r, rad_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};
  assign sq_ge = (trem >= trial);
  assign dlen  = sh_r ? {root_r, 1'b0} : {1'b0, root_r};
  assign f1    = !anchor_r[seg_r];
  assign f2    = !anchor_r[seg_p1];
  assign skip  = (dlen == '0) || (!f1 && !f2);
  assign kval  = $signed({2'b00, dlen}) - $signed({4'b0000, rest_r});
  assign opa   = axis_r ? ay_r : ax_r;
  assign phi   = opa * kabs_r[33:17];
  assign num   = 67'(plo_r) + 67'({phi, 17'b0}) + 67'(den_r[33:1]);
  assign dtr   = {div_rem_r, div_q_r[35]};
  assign dge   = (dtr >= {1'b0, den_r});
  assign cneg  = (axis_r ? dyn_r : dxn_r) != kneg_r;
  assign corr  = cneg ? -$signed({1'b0, div_q_r}) : $signed({1'b0, div_q_r});
  assign p1    = axis_r ? cy_r : cx_r;
  assign p2    = axis_r ? ny_r : nx_r;
  assign s1    = sat32(40'(p1) + 40'(corr));
  assign s2    = sat32(40'(p2) - 40'(corr));

  always_comb begin
    case (state_r)
      ST_R_LD: ra = '0;
      ST_S_RD: ra = seg_p1;
      default: ra = idx_r;
    endcase
  end

  always_comb begin
    pos_we  = 1'b0;
    pos_wa  = idx_r;
    pos_wd  = {cy_r, cx_r};
    prev_we = 1'b0;
    prev_wa = idx_r;
    prev_wd = {ipy_r, ipx_r};
    anc_we  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && idx_ok) begin
          pos_we  = (in_req_type == REQ_LOAD);
          prev_we = (in_req_type == REQ_LOAD) || (in_req_type == REQ_PREV);
          anc_we  = (in_req_type == REQ_ANCHOR);
        end
        pos_wa  = in_idx;
        pos_wd  = {in_y_value, in_x_value};
        prev_wa = in_idx;
        prev_wd = {in_y_value, in_x_value};
      end
      ST_I_WR: begin
        pos_we  = 1'b1;
        pos_wd  = anchored ? anc_rd_r : {newy, newx};
        prev_we = !anchored;
      end
      ST_S_WB: begin
        pos_we = 1'b1;
        pos_wa = seg_r;
      end
      ST_R_END: begin
        pos_we = 1'b1;
        pos_wa = n_m1[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (anc_we) anc_mem[in_idx] <= {in_y_value, in_x_value};
    pos_rd_r  <= pos_mem[ra];
    prev_rd_r <= prev_mem[ra];
    anc_rd_r  <= anc_mem[ra];
    ra_r      <= ra;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gravity_r   <= '0;
      rest_r      <= '0;
      count_r     <= 7'd1;
      force_x_r   <= '0;
      force_y_r   <= '0;
      pos_vld_r   <= '0;
      prev_vld_r  <= '0;
      anchor_r    <= '0;
      idx_r       <= '0;
      seg_r       <= '0;
      pass_r      <= '0;
      cnt_r       <= '0;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_GRAVITY: gravity_r <= $signed(cfg_data);
          CFG_REST:    rest_r    <= cfg_data[30:0];
          CFG_COUNT:   count_r   <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (pos_we) pos_vld_r[pos_wa] <= 1'b1;
      if (prev_we) prev_vld_r[prev_wa] <= 1'b1;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            idx_r <= '0;
            case (in_req_type)
              REQ_ANCHOR: if (idx_ok) anchor_r[in_idx] <= 1'b1;
              REQ_CLEAR:  anchor_r <= '0;
              REQ_FORCE: begin
                force_x_r <= sat32(40'(force_x_r) + 40'(in_x_value));
                force_y_r <= sat32(40'(force_y_r) + 40'(in_y_value));
              end
              REQ_STEP: begin
                if (in_time_step == '0) begin
                  if (n_use != '0) state_r <= ST_E_RD;
                end else if (n_use == '0) begin
                  force_x_r <= '0;
                  force_y_r <= '0;
                end else begin
                  state_r <= ST_I_RD;
                end
              end
              REQ_READ: if (n_use != '0) state_r <= ST_E_RD;
              default: ;
            endcase
          end
        end
        ST_I_RD:  state_r <= ST_I_MUL;
        ST_I_MUL: state_r <= ST_I_WR;
        ST_I_WR: begin
          if (last_pt) begin
            if (n_use >= NW'(2)) begin
              pass_r  <= '0;
              state_r <= ST_R_LD;
            end else begin
              force_x_r <= '0;
              force_y_r <= '0;
              idx_r     <= '0;
              state_r   <= ST_E_RD;
            end
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= ST_I_RD;
          end
        end
        ST_R_LD:  state_r <= ST_R_LDW;
        ST_R_LDW: begin
          seg_r   <= '0;
          state_r <= ST_S_RD;
        end
        ST_S_RD:   state_r <= ST_S_GET;
        ST_S_GET:  state_r <= ST_S_DIFF;
        ST_S_DIFF: state_r <= ST_S_SQ1;
        ST_S_SQ1:  state_r <= ST_S_SQ2;
        ST_S_SQ2: begin
          cnt_r   <= '0;
          state_r <= ST_S_SQRT;
        end
        ST_S_SQRT: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd31) state_r <= ST_S_CHK;
        end
        ST_S_CHK: begin
          axis_r  <= 1'b0;
          state_r <= skip ? ST_S_WB : ST_S_MLO;
        end
        ST_S_MLO: state_r <= ST_S_MHI;
        ST_S_MHI: begin
          cnt_r   <= '0;
          state_r <= ST_S_DIV;
        end
        ST_S_DIV: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd35) state_r <= ST_S_APP;
        end
        ST_S_APP: begin
          if (!axis_r) begin
            axis_r  <= 1'b1;
            state_r <= ST_S_MLO;
          end else begin
            state_r <= ST_S_WB;
          end
        end
        ST_S_WB: begin
          if ((NW'(seg_r) + NW'(2)) == n_use) begin
            state_r <= ST_R_END;
          end else begin
            seg_r   <= seg_p1;
            state_r <= ST_S_RD;
          end
        end
        ST_R_END: begin
          if (pass_r == 4'(RELAX_PASSES - 1)) begin
            force_x_r <= '0;
            force_y_r <= '0;
            idx_r     <= '0;
            state_r   <= ST_E_RD;
          end else begin
            pass_r  <= pass_r + 4'd1;
            state_r <= ST_R_LD;
          end
        end
        ST_E_RD: state_r <= ST_E_OUT;
        ST_E_OUT: begin
          if (out_ld) begin
            out_valid_r <= 1'b1;
            if (last_pt) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r   <= idx_r + AW'(1);
              state_r <= ST_E_RD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) dt_r <= in_time_step;
      end
      ST_I_MUL: begin
        ipx_r <= $signed(pos_q[31:0]);
        ipy_r <= $signed(pos_q[63:32]);
        mvx_r <= mvx;
        mvy_r <= mvy;
        mdx_r <= mdx;
        mdy_r <= mdy;
      end
      ST_R_LDW: begin
        cx_r <= $signed(pos_q[31:0]);
        cy_r <= $signed(pos_q[63:32]);
      end
      ST_S_GET: begin
        nx_r <= $signed(pos_q[31:0]);
        ny_r <= $signed(pos_q[63:32]);
      end
      ST_S_DIFF: begin
        ax_r  <= adx[31:0];
        ay_r  <= ady[31:0];
        dxn_r <= dx[32];
        dyn_r <= dy[32];
        sh_r  <= adx[31] | ady[31];
        axs_r <= (adx[31] | ady[31]) ? adx[31:1] : adx[30:0];
        ays_r <= (adx[31] | ady[31]) ? ady[31:1] : ady[30:0];
      end
      ST_S_SQ1: sqx_r <= axs_r * axs_r;
      ST_S_SQ2: begin
        rad_r    <= 64'(sqx_r) + 64'(sqy);
        sq_rem_r <= '0;
        root_r   <= '0;
      end
      ST_S_SQRT: begin
        sq_rem_r <= sq_ge ? 34'(trem - trial) : trem[33:0];
        root_r   <= {root_r[30:0], sq_ge};
        rad_r    <= {rad_r[61:0], 2'b00};
      end
      ST_S_CHK: begin
        kneg_r <= kval[34];
        kabs_r <= kval[34] ? 34'(-kval) : 34'(kval);
        den_r  <= (f1 && f2) ? {dlen, 1'b0} : {1'b0, dlen};
        f1_r   <= f1;
        f2_r   <= f2;
      end
      ST_S_MLO: plo_r <= opa * kabs_r[16:0];
      ST_S_MHI: begin
        div_rem_r <= 34'(num[66:36]);
        div_q_r   <= num[35:0];
      end
      ST_S_DIV: begin
        div_rem_r <= dge ? 34'(dtr - {1'b0, den_r}) : dtr[33:0];
        div_q_r   <= {div_q_r[34:0], dge};
      end
      ST_S_APP: begin
        if (f1_r) begin
          if (axis_r) cy_r <= s1;
          else cx_r <= s1;
        end
        if (f2_r) begin
          if (axis_r) ny_r <= s2;
          else nx_r <= s2;
        end
      end
      ST_S_WB: begin
        cx_r <= nx_r;
        cy_r <= ny_r;
      end
      ST_E_OUT: begin
        if (out_ld) begin
          out_index_r <= IDX_W'(idx_r);
          out_x_r     <= $signed(pos_q[31:0]);
          out_y_r     <= $signed(pos_q[63:32]);
          out_last_r  <= last_pt;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sv/vrr_checker.sv
// ----------------------------------------------------------------------------
// vrr_checker
// Port-level checks on the rope core's result channel and run framing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vrr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [vrr_pkg::IDX_W-1:0]         out_index,
  input logic signed [vrr_pkg::CRD_W-1:0]  out_pos_x,
  input logic signed [vrr_pkg::CRD_W-1:0]  out_pos_y,
  input logic                              out_last_point
);

  `VRR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `VRR_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_index) && $stable(out_pos_x) && $stable(out_pos_y))
  `VRR_ASSERT_IMP(a_run_busy, out_valid && !out_last_point, !in_ready)
  `VRR_ASSERT_NXT(a_run_gap, out_valid && out_ready && out_last_point, !out_valid)

endmodule

bind verlet_rope_relaxation_core vrr_checker u_vrr_checker (.*);
